// ===== rtl/camera_frame_deframer_core_macros.svh =====
// Assertion macros for the checker file.
`ifndef CAMERA_FRAME_DEFRAMER_CORE_MACROS_SVH
`define CAMERA_FRAME_DEFRAMER_CORE_MACROS_SVH

// Checked on every rising edge outside reset.
`define CFD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfd assertion failed");

// Checked on every rising edge, reset included.
`define CFD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cfd assertion failed");

`endif

// ===== rtl/cfd_pkg.sv =====
`timescale 1ns / 1ps
package cfd_pkg;

  // Frame bytes
  localparam logic [7:0] HDR_FIRST  = 8'h2C;
  localparam logic [7:0] HDR_SECOND = 8'h12;
  localparam logic [7:0] END_MARK   = 8'h5B;

  // Longest frame, header included
  localparam int FRAME_MAX_DEF = 13;
  // Fewest bytes a frame needs to report the four bytes before its end
  localparam int FRAME_MIN_REPORT = 5;

  typedef enum logic [1:0] {
    PH_HUNT_FIRST  = 2'd0,
    PH_HUNT_SECOND = 2'd1,
    PH_PAYLOAD     = 2'd2,
    PH_CLOSED      = 2'd3
  } cfd_phase_t;

  typedef struct packed {
    logic [7:0]        no_color_flag;
    logic signed [7:0] correction_whole;
    logic [7:0]        correction_fraction;
    logic [7:0]        all_color_flag;
    logic              ended_by_marker;
  } cfd_result_t;

endpackage

// ===== rtl/cfd_parser.sv =====
`timescale 1ns / 1ps
module cfd_parser #(
  parameter int FRAME_MAX = cfd_pkg::FRAME_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output cfd_pkg::cfd_result_t res
);
  import cfd_pkg::*;

  localparam int CNT_W = $clog2(FRAME_MAX + 1);

  cfd_phase_t       phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       hist_r [4];
  logic             push;

  assign count_inc = count_r + CNT_W'(1);

  // Phase and byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_FIRST;
      count_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Last four stored frame bytes, oldest in entry 0
  always_ff @(posedge clk) begin
    if (take && push) begin
      hist_r[0] <= hist_r[1];
      hist_r[1] <= hist_r[2];
      hist_r[2] <= hist_r[3];
      hist_r[3] <= rx_byte;
    end
  end

  // Next phase, count and result
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    push      = 1'b0;
    res_valid = 1'b0;
    res.no_color_flag       = hist_r[0];
    res.correction_whole    = hist_r[1];
    res.correction_fraction = hist_r[2];
    res.all_color_flag      = hist_r[3];
    res.ended_by_marker     = (rx_byte == END_MARK);
    unique case (phase_r)
      PH_HUNT_SECOND: begin
        if (rx_byte == HDR_SECOND) begin
          push      = 1'b1;
          count_nxt = CNT_W'(2);
          phase_nxt = PH_PAYLOAD;
        end else begin
          count_nxt = '0;
          phase_nxt = PH_HUNT_FIRST;
        end
      end
      PH_PAYLOAD: begin
        push      = 1'b1;
        count_nxt = count_inc;
        if (count_inc >= CNT_W'(FRAME_MAX) || rx_byte == END_MARK) begin
          phase_nxt = PH_CLOSED;
          // Marker as first or second payload byte: nothing to report
          res_valid = (count_inc >= CNT_W'(FRAME_MIN_REPORT));
        end
      end
      PH_HUNT_FIRST, PH_CLOSED: begin
        if (rx_byte == HDR_FIRST) begin
          push      = 1'b1;
          count_nxt = CNT_W'(1);
          phase_nxt = PH_HUNT_SECOND;
        end else begin
          count_nxt = '0;
          phase_nxt = PH_HUNT_FIRST;
        end
      end
      default: begin
        phase_nxt = PH_HUNT_FIRST;
        count_nxt = '0;
      end
    endcase
  end

endmodule

// ===== rtl/camera_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Ports                                   Handshake
// in_       input      in_rx_byte                              in_valid / in_stall
// out_      output     out_no_color_flag, out_correction_*,    out_valid / out_stall
//                      out_all_color_flag, out_ended_by_marker
//
// One byte per cycle while in_stall is low; a frame-closing byte loads its result
// into the output register, or into the skid register if the output is stalled.
// Parser state updates in one pass; reset is synchronous on rst_n, no clearing pass.
// A stalled result parks in the output register; one more result fits in a
// skid register, and in_stall rises only while that skid register is full.
module camera_frame_deframer_core #(
  parameter int FRAME_MAX = cfd_pkg::FRAME_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_no_color_flag,
  output logic signed [7:0] out_correction_whole,
  output logic [7:0]        out_correction_fraction,
  output logic [7:0]        out_all_color_flag,
  output logic              out_ended_by_marker
);
  import cfd_pkg::*;

  logic        take;
  logic        res_valid;
  cfd_result_t res;
  logic        new_valid;
  logic        load_out;

  logic        out_valid_r, out_valid_nxt;
  cfd_result_t out_data_r;
  logic        skid_valid_r, skid_valid_nxt;
  cfd_result_t skid_data_r;

  assign in_stall  = skid_valid_r;
  assign take      = in_valid && !skid_valid_r;
  assign new_valid = take && res_valid;
  assign load_out  = !out_valid_r || !out_stall;

  cfd_parser #(
    .FRAME_MAX (FRAME_MAX)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output and skid valid bits
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (load_out) begin
      out_valid_nxt  = skid_valid_r || new_valid;
      skid_valid_nxt = 1'b0;
    end else if (new_valid) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payloads
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (new_valid) begin
      skid_data_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_no_color_flag       = out_data_r.no_color_flag;
  assign out_correction_whole    = out_data_r.correction_whole;
  assign out_correction_fraction = out_data_r.correction_fraction;
  assign out_all_color_flag      = out_data_r.all_color_flag;
  assign out_ended_by_marker     = out_data_r.ended_by_marker;

endmodule

// ===== rtl/cfd_checker.sv =====
`timescale 1ns / 1ps
`include "camera_frame_deframer_core_macros.svh"
module cfd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        in_rx_byte,
  input logic              out_valid,
  input logic              out_stall,
  input logic [7:0]        out_no_color_flag,
  input logic signed [7:0] out_correction_whole,
  input logic [7:0]        out_correction_fraction,
  input logic [7:0]        out_all_color_flag,
  input logic              out_ended_by_marker
);

  // A stalled result holds
  `CFD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_no_color_flag) && $stable(out_correction_whole) && $stable(out_correction_fraction) && $stable(out_all_color_flag) && $stable(out_ended_by_marker))

  // A stalled input byte holds
  `CFD_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_rx_byte))

  // Input backs up only behind a waiting result
  `CFD_ASSERT(a_stall_needs_out, clk, rst_n, in_stall |-> out_valid)

  // Skid fills only while the output is stalled
  `CFD_ASSERT(a_stall_rise, clk, rst_n, $rose(in_stall) |-> $past(out_valid && out_stall))

  // Reset empties both result registers
  `CFD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !in_stall)

endmodule

bind camera_frame_deframer_core cfd_checker u_cfd_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_stall                (in_stall),
  .in_rx_byte              (in_rx_byte),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_no_color_flag       (out_no_color_flag),
  .out_correction_whole    (out_correction_whole),
  .out_correction_fraction (out_correction_fraction),
  .out_all_color_flag      (out_all_color_flag),
  .out_ended_by_marker     (out_ended_by_marker)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import cfd_pkg::*;

  localparam int FRAME_LEN_MAX = FRAME_MAX_DEF;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SHOW_MAX      = 10;

  // Tracks the frame parser and keeps the reports it should produce, oldest first
  class frame_report_board;
    cfd_phase_t  phase;
    logic [3:0]  frame_bytes;
    logic [7:0]  last4 [4];
    cfd_result_t reports [$];
    int          mismatches;
    int          checked;
    int          by_marker;
    int          by_limit;
    int          early_closes;

    function new();
      phase       = PH_HUNT_FIRST;
      frame_bytes = '0;
      foreach (last4[i]) last4[i] = '0;
    endfunction

    function void shift_in(logic [7:0] b);
      last4[0] = last4[1];
      last4[1] = last4[2];
      last4[2] = last4[3];
      last4[3] = b;
    endfunction

    // One accepted byte: advance the parser, queue a report on frame close
    function void take_byte(logic [7:0] b);
      cfd_result_t r;
      case (phase)
        PH_HUNT_FIRST: begin
          if (b == HDR_FIRST) begin
            shift_in(b);
            frame_bytes = 4'd1;
            phase = PH_HUNT_SECOND;
          end else begin
            frame_bytes = '0;
          end
        end
        PH_HUNT_SECOND: begin
          if (b == HDR_SECOND) begin
            shift_in(b);
            frame_bytes = 4'd2;
            phase = PH_PAYLOAD;
          end else begin
            frame_bytes = '0;
            phase = PH_HUNT_FIRST;
          end
        end
        PH_PAYLOAD: begin
          frame_bytes = frame_bytes + 4'd1;
          if (frame_bytes >= FRAME_LEN_MAX || b == END_MARK) begin
            phase = PH_CLOSED;
            if (frame_bytes >= FRAME_MIN_REPORT) begin
              r.no_color_flag       = last4[0];
              r.correction_whole    = last4[1];
              r.correction_fraction = last4[2];
              r.all_color_flag      = last4[3];
              r.ended_by_marker     = (b == END_MARK);
              reports.push_back(r);
              if (b == END_MARK) by_marker++;
              else by_limit++;
            end else begin
              early_closes++;
            end
          end
          shift_in(b);
        end
        default: begin
          phase = PH_HUNT_FIRST;
          frame_bytes = '0;
          if (b == HDR_FIRST) begin
            shift_in(b);
            frame_bytes = 4'd1;
            phase = PH_HUNT_SECOND;
          end
        end
      endcase
    endfunction

    function void note_mismatch(string what, cfd_result_t exp_r, cfd_result_t got_r);
      mismatches++;
      if (mismatches <= SHOW_MAX)
        $display("%0t: %s: expected %02h %0d %02h %02h %b, got %02h %0d %02h %02h %b",
                 $time, what,
                 exp_r.no_color_flag, exp_r.correction_whole, exp_r.correction_fraction,
                 exp_r.all_color_flag, exp_r.ended_by_marker,
                 got_r.no_color_flag, got_r.correction_whole, got_r.correction_fraction,
                 got_r.all_color_flag, got_r.ended_by_marker);
    endfunction

    // One accepted report against the oldest expectation
    function void check_report(cfd_result_t got_r);
      cfd_result_t exp_r;
      checked++;
      if (reports.size() == 0) begin
        exp_r = '0;
        note_mismatch("report with none pending", exp_r, got_r);
      end else begin
        exp_r = reports.pop_front();
        if (got_r.no_color_flag !== exp_r.no_color_flag ||
            got_r.correction_whole !== exp_r.correction_whole ||
            got_r.correction_fraction !== exp_r.correction_fraction ||
            got_r.all_color_flag !== exp_r.all_color_flag ||
            got_r.ended_by_marker !== exp_r.ended_by_marker)
          note_mismatch("report mismatch", exp_r, got_r);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_no_color_flag;
  logic signed [7:0] out_correction_whole;
  logic [7:0]        out_correction_fraction;
  logic [7:0]        out_all_color_flag;
  logic              out_ended_by_marker;

  frame_report_board board = new();
  int  bytes_sent;
  int  burst_left;
  int  cycles;
  int  input_stall_cycles;
  int  holds_done;
  int  holds_asked;

  camera_frame_deframer_core #(
    .FRAME_MAX (FRAME_LEN_MAX)
  ) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_rx_byte              (in_rx_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_no_color_flag       (out_no_color_flag),
    .out_correction_whole    (out_correction_whole),
    .out_correction_fraction (out_correction_fraction),
    .out_all_color_flag      (out_all_color_flag),
    .out_ended_by_marker     (out_ended_by_marker)
  );

  always #5 clk = ~clk;

  // Result monitor, sampled at the rising edge
  always @(posedge clk) begin
    cfd_result_t got_r;
    if (rst_n && out_valid && !out_stall) begin
      got_r.no_color_flag       = out_no_color_flag;
      got_r.correction_whole    = out_correction_whole;
      got_r.correction_fraction = out_correction_fraction;
      got_r.all_color_flag      = out_all_color_flag;
      got_r.ended_by_marker     = out_ended_by_marker;
      board.check_report(got_r);
    end
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d reports pending", cycles,
               board.reports.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: randomly chosen stall modes, plus a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holds_asked > holds_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        default: out_stall = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // One byte transfer; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    in_valid = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(b);
    bytes_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Sender pauses until every queued report has come out
  task automatic drain_reports();
    in_valid = 1'b0;
    while (board.reports.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0: b = 8'h00;
      1: b = 8'hFF;
      2: b = 8'h80;
      3: b = 8'h7F;
      4: b = HDR_FIRST;
      5: b = HDR_SECOND;
      default: begin
        do b = 8'($urandom_range(0, 255)); while (b == END_MARK);
      end
    endcase
    return b;
  endfunction

  // Header, random payload, then the marker or the length limit
  task automatic send_random_frame();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    if (sel < 70) begin
      n = $urandom_range(0, FRAME_LEN_MAX - 3);
      repeat (n) send_byte(payload_byte());
      send_byte(END_MARK);
    end else begin
      repeat (FRAME_LEN_MAX - 2) send_byte(payload_byte());
    end
  endtask

  initial begin
    int sel;
    int next_hold;
    int next_drain;
    burst_left = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: noise, broken header, early markers, shortest report
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(END_MARK);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h00);
    send_byte(END_MARK);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(END_MARK);
    // Marker landing exactly on the length limit
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'hFF);
    send_byte(8'h00);
    repeat (FRAME_LEN_MAX - 8) send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(END_MARK);
    drain_reports();

    // Random: mostly well-formed frames, some noise and broken headers
    next_hold = 300;
    next_drain = 600;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
        send_random_frame();
      end else if (sel < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(HDR_FIRST);
        send_byte(($urandom_range(0, 2) == 0) ? HDR_FIRST : 8'($urandom_range(0, 255)));
      end
      if (bytes_sent >= next_hold) begin
        holds_asked++;
        next_hold += 600;
      end
      if (bytes_sent >= next_drain) begin
        drain_reports();
        next_drain += 600;
      end
    end

    drain_reports();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d reports (%0d by marker, %0d at the length limit), %0d early closes",
             board.checked, board.by_marker, board.by_limit, board.early_closes);
    $display("input stalled for %0d cycles over %0d long output hold-offs",
             input_stall_cycles, holds_done);
    if (board.mismatches == 0 && board.reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d reports never seen", board.mismatches,
               board.reports.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
